// ===== src/rft_pkg.sv =====
// shared constants, types and helpers for the route file tokenizer
`default_nettype none

package rft_pkg;

    localparam int NAME_MAX = 32;
    localparam int ADDR_W   = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
    localparam int CNT_W    = $clog2(NAME_MAX + 1);

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_PERIOD  = 8'h2E;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CTRL_MASK  = 8'hE0;

    localparam logic [15:0] LINE_MAX  = 16'hFFFF;

    localparam logic [2:0] TK_NAME    = 3'd0;
    localparam logic [2:0] TK_COMMA   = 3'd1;
    localparam logic [2:0] TK_SEMI    = 3'd2;
    localparam logic [2:0] TK_PERIOD  = 3'd3;
    localparam logic [2:0] TK_EQUALS  = 3'd4;
    localparam logic [2:0] TK_ERROR   = 3'd5;
    localparam logic [2:0] TK_END     = 3'd6;

    typedef enum logic [1:0] {
        LEX_IDLE    = 2'd0,
        LEX_COMMENT = 2'd1,
        LEX_WORD    = 2'd2
    } t_lex;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_NAME  = 2'd1,
        ST_DELIM = 2'd2
    } t_state;

    function automatic logic [2:0] delim_kind(input logic [7:0] c);
        logic [2:0] k;
        begin
            case (c)
                CH_COMMA:  k = TK_COMMA;
                CH_SEMI:   k = TK_SEMI;
                CH_PERIOD: k = TK_PERIOD;
                default:   k = TK_EQUALS;
            endcase
            return k;
        end
    endfunction

endpackage

`default_nettype wire

// ===== src/route_file_tokenizer.sv =====
// route file tokenizer: byte stream in, token stream out, name buffer in a memory
`default_nettype none

// One input transaction carries one text byte (tdata) and an end-of-input
// flag (tuser). Each byte yields zero or more tokens on the master side:
// tdata holds the character and the line number, tuser the token kind and
// the character-valid flag; tlast marks the final token caused by that byte.
// Names come out one character per token.
// Timing: a token given directly by a byte sits in the output register in
// the cycle after the byte is taken. A byte that closes a name moves the
// block to the name state, which holds the input and reads the name memory
// one entry per cycle while the output register is free, one token per
// character (one for an empty name), then sends any trailing delimiter.
// A byte that gives no token or a single token does not hold the input.
// Input is taken only while no name run or trailing delimiter is in
// progress and the output register is empty or being drained.
// Reset: mode idle, name empty, line count one, end flag clear. The name
// memory is not cleared; only entries written since the name began are read.
// A stalled receiver holds the output register and with it the whole block.
module route_file_tokenizer
    import rft_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_value
    input  wire logic [0:0]  s_axis_tuser,   // [0] kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [7:0] char_value, [23:8] line_number
    output logic [3:0]       m_axis_tuser,   // [2:0] token_kind, [3] char_valid
    output logic             m_axis_tlast
);

    logic [7:0] name_mem [NAME_MAX];

    t_state           r_state, n_state;
    t_lex             r_mode, n_mode;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ended, n_ended;
    logic [15:0]      r_line, n_line;
    logic [ADDR_W-1:0] r_ptr, n_ptr;
    logic [CNT_W-1:0] r_len, n_len;
    logic             r_dpend, n_dpend;
    logic [7:0]       r_dchar, n_dchar;
    logic [7:0]       r_rd_data;

    logic             r_out_valid;
    logic [2:0]       r_out_kind;
    logic [7:0]       r_out_char;
    logic             r_out_cvalid;
    logic [15:0]      r_out_line;
    logic             r_out_last;

    logic             out_free, in_acc;
    logic [7:0]       c;
    logic             is_end, is_sep, is_delim, is_pct, is_ctrl;
    logic             d_direct;
    logic [2:0]       d_kind;
    logic [7:0]       d_char;
    logic             d_cvalid;
    logic             start_emit, last_char;
    logic             wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic             ld, ld_cvalid, ld_last;
    logic [2:0]       ld_kind;
    logic [7:0]       ld_char;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) && out_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign c             = s_axis_tdata;

    // byte classes, in the order of precedence
    always_comb begin
        is_end   = r_ended || s_axis_tuser[0] || (c == CH_NUL);
        is_sep   = (c == CH_NL) || (c == CH_SPACE);
        is_delim = (c == CH_COMMA) || (c == CH_SEMI) || (c == CH_PERIOD)
                   || (c == CH_EQUALS);
        is_pct   = (c == CH_PERCENT);
        is_ctrl  = ((c & CTRL_MASK) == 8'h00);
    end

    // tokens given straight at acceptance
    always_comb begin
        d_direct = 1'b0;
        d_kind   = TK_END;
        d_char   = 8'h00;
        d_cvalid = 1'b0;
        if (is_end) begin
            d_direct = 1'b1;
        end else if (is_sep || is_pct) begin
            d_direct = 1'b0;
        end else if (is_delim) begin
            d_direct = (r_mode == LEX_IDLE);
            d_kind   = delim_kind(c);
            d_char   = c;
            d_cvalid = 1'b1;
        end else if (is_ctrl) begin
            d_direct = 1'b1;
            d_kind   = TK_ERROR;
        end
    end

    assign last_char = (r_len == '0) || (CNT_W'(r_ptr) == r_len - CNT_W'(1));

    // next state
    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_count    = r_count;
        n_ended    = r_ended;
        n_line     = r_line;
        n_ptr      = r_ptr;
        n_len      = r_len;
        n_dpend    = r_dpend;
        n_dchar    = r_dchar;
        start_emit = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = r_count[ADDR_W-1:0];
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (is_end) begin
                        n_ended = 1'b1;
                        n_count = '0;
                    end else if (is_sep) begin
                        if ((c == CH_NL) && (r_line != LINE_MAX)) begin
                            n_line = r_line + 16'd1;
                        end
                        if ((c == CH_NL) && (r_mode == LEX_COMMENT)) begin
                            n_mode = LEX_IDLE;
                        end else if (r_mode == LEX_WORD) begin
                            start_emit = 1'b1;
                            n_dpend    = 1'b0;
                            n_mode     = LEX_IDLE;
                        end
                    end else if (is_delim) begin
                        if (r_mode == LEX_WORD) begin
                            start_emit = 1'b1;
                            n_dpend    = 1'b1;
                            n_dchar    = c;
                            n_mode     = LEX_IDLE;
                        end
                    end else if (is_pct) begin
                        if (r_mode == LEX_IDLE) begin
                            n_mode = LEX_COMMENT;
                        end
                    end else if (is_ctrl) begin
                        n_count = '0;
                    end else if (r_mode == LEX_IDLE) begin
                        wr_en   = 1'b1;
                        wr_addr = '0;
                        n_count = CNT_W'(1);
                        n_mode  = LEX_WORD;
                    end else if (r_mode == LEX_WORD) begin
                        if (r_count >= CNT_W'(NAME_MAX)) begin
                            // buffer full: flush it and drop this byte
                            start_emit = 1'b1;
                            n_dpend    = 1'b0;
                        end else begin
                            wr_en   = 1'b1;
                            n_count = r_count + CNT_W'(1);
                        end
                    end
                    if (start_emit) begin
                        n_state = ST_NAME;
                        n_ptr   = '0;
                        n_len   = r_count;
                        n_count = '0;
                    end
                end
            end
            ST_NAME: begin
                if (out_free) begin
                    if (last_char) begin
                        n_state = r_dpend ? ST_DELIM : ST_IDLE;
                        n_ptr   = '0;
                    end else begin
                        n_ptr = r_ptr + ADDR_W'(1);
                    end
                end
            end
            ST_DELIM: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // output register load
    always_comb begin
        ld        = 1'b0;
        ld_kind   = d_kind;
        ld_char   = d_char;
        ld_cvalid = d_cvalid;
        ld_last   = 1'b1;
        case (r_state)
            ST_IDLE: begin
                ld = in_acc && d_direct;
            end
            ST_NAME: begin
                ld        = out_free;
                ld_kind   = TK_NAME;
                ld_char   = (r_len == '0) ? 8'h00 : r_rd_data;
                ld_cvalid = (r_len != '0);
                ld_last   = last_char && !r_dpend;
            end
            ST_DELIM: begin
                ld        = out_free;
                ld_kind   = delim_kind(r_dchar);
                ld_char   = r_dchar;
                ld_cvalid = 1'b1;
            end
            default: begin
                ld = 1'b0;
            end
        endcase
    end

    // name memory; read address is the next pointer so the data lines up
    // with r_ptr, and no write happens while a name is being read out
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            name_mem[wr_addr] <= c;
        end
        r_rd_data <= name_mem[n_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= LEX_IDLE;
            r_count     <= '0;
            r_ended     <= 1'b0;
            r_line      <= 16'd1;
            r_ptr       <= '0;
            r_len       <= '0;
            r_dpend     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_count <= n_count;
            r_ended <= n_ended;
            r_line  <= n_line;
            r_ptr   <= n_ptr;
            r_len   <= n_len;
            r_dpend <= n_dpend;
            if (ld) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dchar <= n_dchar;
        if (ld) begin
            r_out_kind   <= ld_kind;
            r_out_char   <= ld_char;
            r_out_cvalid <= ld_cvalid;
            r_out_line   <= r_line;
            r_out_last   <= ld_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {r_out_line, r_out_char};
    assign m_axis_tuser  = {r_out_cvalid, r_out_kind};

    // an end token is only ever produced once the end flag is set
    a_end_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (r_out_kind == TK_END)) |-> r_ended)
        else $error("end token without end flag");

    // read pointer stays within the name being emitted
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_NAME) && (r_len != '0)) |-> (CNT_W'(r_ptr) < r_len))
        else $error("name read pointer past name length");

    // name fill never exceeds the buffer
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |-> (r_count <= CNT_W'(NAME_MAX)))
        else $error("name count beyond buffer size");

    // line count never wraps to zero
    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_line != 16'd0))
        else $error("line counter wrapped");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// self-checking testbench for the route file tokenizer: directed script, random text, sticky end
module testbench
    import rft_pkg::*;
();

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int RANDOM_BYTES = 220;
    localparam int N_OPEN = 20;
    localparam int N_ROWS = 28;
    localparam int MAX_WAIT = 17;

    typedef struct packed {
        logic [2:0]  tk;
        logic [7:0]  cv;
        logic        cv_ok;
        logic [15:0] line;
        logic        last;
    } token_t;

    typedef struct packed {
        logic        eoi;
        logic [7:0]  ch;
        logic        typed;
        logic [2:0]  tk;
        logic [7:0]  cv;
        logic        cv_ok;
        logic [15:0] line;
    } script_row_t;

    // rows 0..N_OPEN-1 run straight after reset, the rest at the very end of the run
    localparam script_row_t SCRIPT [N_ROWS] = '{
        '{1'b0, CH_COMMA,   1'b1, TK_COMMA,  CH_COMMA,  1'b1, 16'd1},
        '{1'b0, CH_SEMI,    1'b1, TK_SEMI,   CH_SEMI,   1'b1, 16'd1},
        '{1'b0, CH_PERIOD,  1'b1, TK_PERIOD, CH_PERIOD, 1'b1, 16'd1},
        '{1'b0, CH_EQUALS,  1'b1, TK_EQUALS, CH_EQUALS, 1'b1, 16'd1},
        '{1'b0, 8'h01,      1'b1, TK_ERROR,  8'h00,     1'b0, 16'd1},
        '{1'b0, 8'h1F,      1'b1, TK_ERROR,  8'h00,     1'b0, 16'd1},
        '{1'b0, CH_NL,      1'b0, TK_NAME,   8'h00,     1'b0, 16'd0},
        '{1'b0, 8'h61,      1'b0, TK_NAME,   8'h00,     1'b0, 16'd0},
        '{1'b0, CH_PERCENT, 1'b0, TK_NAME,   8'h00,     1'b0, 16'd0},
        '{1'b0, 8'hFF,      1'b0, TK_NAME,   8'h00,     1'b0, 16'd0},
        '{1'b0, CH_COMMA,   1'b0, TK_NAME,   8'h00,     1'b0, 16'd0},
        '{1'b0, 8'h62,      1'b0, TK_NAME,   8'h00,     1'b0, 16'd0},
        '{1'b0, 8'h1F,      1'b1, TK_ERROR,  8'h00,     1'b0, 16'd2},
        '{1'b0, CH_SPACE,   1'b0, TK_NAME,   8'h00,     1'b0, 16'd0},
        '{1'b0, CH_PERCENT, 1'b0, TK_NAME,   8'h00,     1'b0, 16'd0},
        '{1'b0, CH_SEMI,    1'b0, TK_NAME,   8'h00,     1'b0, 16'd0},
        '{1'b0, 8'h01,      1'b1, TK_ERROR,  8'h00,     1'b0, 16'd2},
        '{1'b0, CH_NL,      1'b0, TK_NAME,   8'h00,     1'b0, 16'd0},
        '{1'b0, 8'h21,      1'b0, TK_NAME,   8'h00,     1'b0, 16'd0},
        '{1'b0, CH_NL,      1'b0, TK_NAME,   8'h00,     1'b0, 16'd0},
        '{1'b0, CH_COMMA,   1'b0, TK_NAME,   8'h00,     1'b0, 16'd0},
        '{1'b0, 8'h80,      1'b0, TK_NAME,   8'h00,     1'b0, 16'd0},
        '{1'b0, CH_NL,      1'b0, TK_NAME,   8'h00,     1'b0, 16'd0},
        '{1'b0, 8'h41,      1'b0, TK_NAME,   8'h00,     1'b0, 16'd0},
        '{1'b0, CH_NUL,     1'b0, TK_NAME,   8'h00,     1'b0, 16'd0},
        '{1'b0, 8'h42,      1'b0, TK_NAME,   8'h00,     1'b0, 16'd0},
        '{1'b1, 8'hFF,      1'b0, TK_NAME,   8'h00,     1'b0, 16'd0},
        '{1'b1, CH_NUL,     1'b0, TK_NAME,   8'h00,     1'b0, 16'd0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [7:0]  s_axis_tdata = 8'h00;    // [7:0] byte_value
    logic [0:0]  s_axis_tuser = 1'b0;     // [0] kind
    logic        m_axis_tready = 1'b0;
    wire         s_axis_tready;
    wire         m_axis_tvalid;
    wire  [23:0] m_axis_tdata;            // [7:0] char_value, [23:8] line_number
    wire  [3:0]  m_axis_tuser;            // [2:0] token_kind, [3] char_valid
    wire         m_axis_tlast;

    route_file_tokenizer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    // tokenizer state as seen from the stream
    t_lex        lex_mode_q = LEX_IDLE;
    logic [7:0]  name_buf [NAME_MAX];
    int          name_len = 0;
    bit          input_ended = 1'b0;
    logic [15:0] line_q = 16'd1;

    token_t      tokens_due[$];
    token_t      step_tokens[$];

    int          errors = 0;
    int          bytes_in = 0;
    int          useful_bytes = 0;
    int          tokens_out = 0;
    int          full_names = 0;
    int          cycles = 0;
    int          rx_stall = 0;
    bit          tx_steady = 1'b0;
    bit          rx_steady = 1'b0;

    function automatic void emit(logic [2:0] tk, logic [7:0] cv, logic ok);
        step_tokens.push_back('{tk, cv, ok, line_q, 1'b0});
    endfunction

    function automatic void flush_name();
        if (name_len == 0) begin
            emit(TK_NAME, 8'h00, 1'b0);
        end else begin
            for (int i = 0; i < name_len; i++)
                emit(TK_NAME, name_buf[i], 1'b1);
        end
        name_len = 0;
    endfunction

    function automatic logic [2:0] delim_code(logic [7:0] c);
        case (c)
            CH_COMMA:  return TK_COMMA;
            CH_SEMI:   return TK_SEMI;
            CH_PERIOD: return TK_PERIOD;
            default:   return TK_EQUALS;
        endcase
    endfunction

    // advances the state by one byte, leaves its tokens in step_tokens;
    // returns whether the byte did anything at all
    function automatic bit tokenize(logic eoi, logic [7:0] c);
        t_lex        mode_was;
        int          len_was;
        logic [15:0] line_was;
        mode_was = lex_mode_q;
        len_was = name_len;
        line_was = line_q;
        step_tokens.delete();
        if (input_ended || eoi || c == CH_NUL) begin
            input_ended = 1'b1;
            name_len = 0;
            emit(TK_END, 8'h00, 1'b0);
        end else if (c == CH_NL || c == CH_SPACE) begin
            if (c == CH_NL && line_q != LINE_MAX)
                line_q++;
            if (c == CH_NL && lex_mode_q == LEX_COMMENT) begin
                lex_mode_q = LEX_IDLE;
            end else if (lex_mode_q == LEX_WORD) begin
                flush_name();
                lex_mode_q = LEX_IDLE;
            end
        end else if (c == CH_COMMA || c == CH_SEMI || c == CH_PERIOD || c == CH_EQUALS) begin
            if (lex_mode_q == LEX_WORD) begin
                flush_name();
                lex_mode_q = LEX_IDLE;
                emit(delim_code(c), c, 1'b1);
            end else if (lex_mode_q == LEX_IDLE) begin
                emit(delim_code(c), c, 1'b1);
            end
        end else if (c == CH_PERCENT) begin
            if (lex_mode_q == LEX_IDLE)
                lex_mode_q = LEX_COMMENT;
        end else if ((c & CTRL_MASK) == 8'h00) begin
            // partial name thrown away, mode kept
            name_len = 0;
            emit(TK_ERROR, 8'h00, 1'b0);
        end else if (lex_mode_q == LEX_IDLE) begin
            name_buf[0] = c;
            name_len = 1;
            lex_mode_q = LEX_WORD;
        end else if (lex_mode_q == LEX_WORD) begin
            if (name_len >= NAME_MAX) begin
                // buffer full: held name goes out, this character is lost
                flush_name();
                full_names++;
            end else begin
                name_buf[name_len] = c;
                name_len++;
            end
        end
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last = 1'b1;
        return step_tokens.size() > 0 || mode_was != lex_mode_q
            || len_was != name_len || line_was != line_q;
    endfunction

    task automatic drive_byte(input logic eoi, input logic [7:0] c);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= c;
        s_axis_tuser <= eoi;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_in++;
    endtask

    task automatic feed(input logic eoi, input logic [7:0] c);
        drive_byte(eoi, c);
        if (tokenize(eoi, c))
            useful_bytes++;
        foreach (step_tokens[i])
            tokens_due.push_back(step_tokens[i]);
    endtask

    task automatic run_row(input int idx);
        script_row_t row;
        row = SCRIPT[idx];
        drive_byte(row.eoi, row.ch);
        if (tokenize(row.eoi, row.ch))
            useful_bytes++;
        if (row.typed) begin
            tokens_due.push_back('{row.tk, row.cv, row.cv_ok, row.line, 1'b1});
        end else begin
            foreach (step_tokens[i])
                tokens_due.push_back(step_tokens[i]);
        end
    endtask

    // hold the input until every outstanding token has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (tokens_due.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [7:0] name_char();
        logic [7:0] c;
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom_range(8'h80, 8'hFF));
        do
            c = 8'($urandom_range(8'h21, 8'h7E));
        while (c == CH_PERCENT || c == CH_COMMA || c == CH_SEMI
            || c == CH_PERIOD || c == CH_EQUALS);
        return c;
    endfunction

    function automatic logic [7:0] delim_char();
        case ($urandom_range(0, 3))
            0:       return CH_COMMA;
            1:       return CH_SEMI;
            2:       return CH_PERIOD;
            default: return CH_EQUALS;
        endcase
    endfunction

    function automatic logic [7:0] ctrl_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 31));
        while (c == CH_NL);
        return c;
    endfunction

    function automatic logic [7:0] comment_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == CH_NL);
        return c;
    endfunction

    function automatic logic [7:0] closer();
        case ($urandom_range(0, 5))
            0:       return CH_SPACE;
            1:       return CH_NL;
            default: return delim_char();
        endcase
    endfunction

    // one fragment of route text: mostly well formed, some broken, some noise
    task automatic random_phrase(input bit long_name);
        int pick;
        int len;
        pick = long_name ? 0 : $urandom_range(0, 99);
        if (pick < 40) begin
            if (long_name || $urandom_range(0, 7) == 0)
                len = $urandom_range(NAME_MAX - 2, NAME_MAX + 8);
            else
                len = $urandom_range(1, 10);
            repeat (len) feed(1'b0, name_char());
            feed(1'b0, closer());
        end else if (pick < 55) begin
            if ($urandom_range(0, 1) == 1)
                feed(1'b0, CH_SPACE);
            feed(1'b0, delim_char());
        end else if (pick < 70) begin
            feed(1'b0, CH_PERCENT);
            repeat ($urandom_range(0, 10)) feed(1'b0, comment_char());
            feed(1'b0, CH_NL);
        end else if (pick < 80) begin
            repeat ($urandom_range(1, 5)) feed(1'b0, name_char());
            feed(1'b0, ctrl_char());
            if ($urandom_range(0, 1) == 1)
                repeat ($urandom_range(1, 3)) feed(1'b0, name_char());
            feed(1'b0, closer());
        end else if (pick < 90) begin
            repeat ($urandom_range(1, 4)) feed(1'b0, name_char());
            feed(1'b0, CH_PERCENT);
            repeat ($urandom_range(0, 4)) feed(1'b0, name_char());
            feed(1'b0, CH_SPACE);
        end else begin
            repeat ($urandom_range(1, 6)) feed(1'b0, 8'($urandom_range(1, 255)));
        end
    endtask

    function automatic void compare_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin : token_sink
        token_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            tokens_out++;
            if (tokens_due.size() == 0) begin
                $error("token transaction with none outstanding: tdata %h tuser %h tlast %b",
                       m_axis_tdata, m_axis_tuser, m_axis_tlast);
                errors++;
            end else begin
                want = tokens_due.pop_front();
                compare_field("token_kind", 32'(want.tk), 32'(m_axis_tuser[2:0]));
                compare_field("char_value", 32'(want.cv), 32'(m_axis_tdata[7:0]));
                compare_field("char_valid", 32'(want.cv_ok), 32'(m_axis_tuser[3]));
                compare_field("line_number", 32'(want.line), 32'(m_axis_tdata[23:8]));
                compare_field("last", 32'(want.last), 32'(m_axis_tlast));
            end
            rx_stall = rx_steady ? 0 : $urandom_range(0, MAX_WAIT);
        end
        if (rx_stall > 0) begin
            rx_stall--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("route_file_tokenizer: mismatch");
            $finish;
        end
    end

    initial begin
        int  target;
        bit  paused;
        bit  first;
        paused = 1'b0;
        first = 1'b1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_OPEN; i++)
            run_row(i);
        drain();

        target = useful_bytes + RANDOM_BYTES;
        while (useful_bytes < target) begin
            tx_steady = ($urandom_range(0, 5) == 0);
            rx_steady = ($urandom_range(0, 5) == 0);
            random_phrase(first);
            first = 1'b0;
            if (!paused && useful_bytes >= target - RANDOM_BYTES / 2) begin
                drain();
                paused = 1'b1;
            end
        end
        drain();
        tx_steady = 1'b0;

        // end of input is sticky, so this part comes last
        for (int i = N_OPEN; i < N_ROWS; i++)
            run_row(i);
        drain();
        repeat (40) @(posedge i_clk);

        $display("tokenizer run: %0d bytes sent, %0d of them effective, %0d tokens checked",
                 bytes_in, useful_bytes, tokens_out);
        $display("covered: %0d overlong names split, comments, control bytes, sticky end",
                 full_names);
        if (errors == 0)
            $display("route_file_tokenizer: match");
        else
            $display("route_file_tokenizer: mismatch");
        $finish;
    end

endmodule

// ===== route_file_tokenizer.f =====
src/rft_pkg.sv
src/route_file_tokenizer.sv
tb/testbench.sv
